// ===== rtl/core/mpls_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI pad learn sequencer package
// Shared widths, codes, state and command/status types.
// ----------------------------------------------------------------------------
package mpls_pkg;

  localparam int TABLE_SLOTS_DEF = 9;

  localparam int GUARD_W = 20;
  localparam int TIME_W  = 48;
  localparam int SRC_W   = 18;
  localparam int CNT_O_W = 4;

  localparam logic [GUARD_W-1:0] GUARD_RST = 20'd350000;

  // MIDI message type codes
  localparam logic [2:0] MT_NOTE_OFF = 3'd0;
  localparam logic [2:0] MT_NOTE_ON  = 3'd1;
  localparam logic [2:0] MT_CC       = 3'd2;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_GUARDED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_CAPTURED  = 3'd3,
    ST_COMPLETE  = 3'd4,
    ST_STARTED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    start;
    logic    rel_chk;
    logic    scan_start;
    logic    scan_step;
    logic    capture;
    logic    out_load;
    status_t res;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic waiting;
    logic ignore;
    logic early;
    logic cnt_zero;
    logic cap_last;
    logic scan_hit;
    logic scan_end;
  } stat_t;

endpackage

// ===== rtl/core/mpls_ifs.sv =====
// ----------------------------------------------------------------------------
// MIDI pad learn sequencer channel interfaces
// Event input, result output and guard-time write channels.
// ----------------------------------------------------------------------------
interface mpls_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  msg_type;
  logic [3:0]  channel;
  logic [6:0]  data_one;
  logic [6:0]  data_two;
  logic [3:0]  cable;
  logic [47:0] time_us;

  modport source (output valid, kind, msg_type, channel, data_one, data_two, cable, time_us,
                  input ready);
  modport sink   (input valid, kind, msg_type, channel, data_one, data_two, cable, time_us,
                  output ready);
endinterface

interface mpls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] filled_count;
  logic [3:0] next_slot;
  logic       learning_on;
  logic       release_wait;

  modport source (output valid, status, filled_count, next_slot, learning_on, release_wait,
                  input ready);
  modport sink   (input valid, status, filled_count, next_slot, learning_on, release_wait,
                  output ready);
endinterface

interface mpls_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/mpls_dp.sv =====
// ----------------------------------------------------------------------------
// MIDI pad learn sequencer datapath
// Word register, slot table, learn state, guard deadline and result register.
// ----------------------------------------------------------------------------
module mpls_dp #(
  parameter int TABLE_SLOTS = mpls_pkg::TABLE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpls_pkg::cmd_t               cmd,
  output mpls_pkg::stat_t              stat,
  input  logic                         in_kind,
  input  logic [2:0]                   in_msg_type,
  input  logic [3:0]                   in_channel,
  input  logic [6:0]                   in_data_one,
  input  logic [6:0]                   in_data_two,
  input  logic [3:0]                   in_cable,
  input  logic [mpls_pkg::TIME_W-1:0]  in_time_us,
  input  logic                         cfg_valid,
  input  logic [mpls_pkg::GUARD_W-1:0] cfg_data,
  output logic [2:0]                   out_status,
  output logic [mpls_pkg::CNT_O_W-1:0] out_filled_count,
  output logic [mpls_pkg::CNT_O_W-1:0] out_next_slot,
  output logic                         out_learning_on,
  output logic                         out_release_wait
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int TW = mpls_pkg::TIME_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);
  localparam logic [CW-1:0] LAST_C  = CW'(TABLE_SLOTS - 1);

  // latched word
  logic          kind_r;
  logic [2:0]    type_r;
  logic [3:0]    ch_r;
  logic [6:0]    num_r;
  logic [6:0]    val_r;
  logic [3:0]    cab_r;
  logic [TW-1:0] time_r;

  // learn state
  logic [CW-1:0]                   cnt_r;
  logic [mpls_pkg::SRC_W-1:0]      held_r;
  logic                            wait_r;
  logic                            learn_r;
  logic [TW-1:0]                   after_r;
  logic [mpls_pkg::GUARD_W-1:0]    guard_r;

  // slot table and scan pipe
  logic [mpls_pkg::SRC_W-1:0] slot_mem [TABLE_SLOTS];
  logic [CW-1:0]              rd_idx_r;
  logic                       rd_vld_r;
  logic [mpls_pkg::SRC_W-1:0] rd_data_r;

  mpls_pkg::status_t out_status_r;
  logic [mpls_pkg::CNT_O_W-1:0] out_filled_r;
  logic [mpls_pkg::CNT_O_W-1:0] out_next_r;
  logic out_learn_r;
  logic out_wait_r;

  logic [mpls_pkg::SRC_W-1:0] src;
  logic [2:0]                 held_type;
  logic                       rel_kind;
  logic                       rel_hit;
  logic                       full;
  logic                       rd_go;
  logic [TW:0]                dl_sum;
  logic [TW-1:0]              dl_sat;

  assign src       = {type_r, ch_r, num_r, cab_r};
  assign held_type = held_r[mpls_pkg::SRC_W-1 -: 3];
  assign full      = (cnt_r >= SLOTS_C);
  assign rd_go     = cmd.scan_step && (rd_idx_r < cnt_r);

  // release of the held source: same channel, number and cable
  always_comb begin
    rel_kind = ((held_type == mpls_pkg::MT_NOTE_ON) &&
                ((type_r == mpls_pkg::MT_NOTE_OFF) ||
                 ((type_r == mpls_pkg::MT_NOTE_ON) && (val_r == '0)))) ||
               ((held_type == mpls_pkg::MT_CC) && (type_r == mpls_pkg::MT_CC) &&
                (val_r == '0));
    rel_hit  = rel_kind && (src[14:0] == held_r[14:0]);
  end

  // guard deadline, saturating at the top of the time range
  always_comb begin
    dl_sum = {1'b0, time_r} + (TW + 1)'(guard_r);
    dl_sat = dl_sum[TW] ? '1 : dl_sum[TW-1:0];
  end

  // status to controller
  always_comb begin
    stat.is_start = !kind_r;
    stat.waiting  = wait_r;
    stat.ignore   = !learn_r ||
                    !((type_r == mpls_pkg::MT_NOTE_ON) || (type_r == mpls_pkg::MT_CC)) ||
                    (val_r == '0);
    stat.early    = (time_r < after_r);
    stat.cnt_zero = (cnt_r == '0);
    stat.cap_last = (cnt_r >= LAST_C);
    stat.scan_hit = rd_vld_r && (rd_data_r == src);
    stat.scan_end = !rd_vld_r && (rd_idx_r == cnt_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      held_r   <= '0;
      wait_r   <= 1'b0;
      learn_r  <= 1'b0;
      after_r  <= '0;
      guard_r  <= mpls_pkg::GUARD_RST;
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        guard_r <= cfg_data;
      end
      if (cmd.start) begin
        cnt_r   <= '0;
        after_r <= '0;
        learn_r <= 1'b1;
        wait_r  <= 1'b0;
      end
      if (cmd.rel_chk && rel_hit) begin
        wait_r <= 1'b0;
      end
      if (cmd.capture) begin
        if (full) begin
          learn_r <= 1'b0;
        end else begin
          cnt_r   <= CW'(cnt_r + 1'b1);
          held_r  <= src;
          wait_r  <= 1'b1;
          after_r <= dl_sat;
          if (cnt_r == LAST_C) begin
            learn_r <= 1'b0;
          end
        end
      end
      // scan pointer: one slot read per cycle
      if (cmd.scan_start) begin
        rd_idx_r <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (rd_go) begin
          rd_idx_r <= CW'(rd_idx_r + 1'b1);
          rd_vld_r <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
      end
    end
  end

  // word register, slot table and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      type_r <= in_msg_type;
      ch_r   <= in_channel;
      num_r  <= in_data_one;
      val_r  <= in_data_two;
      cab_r  <= in_cable;
      time_r <= in_time_us;
    end
    if (cmd.capture && !full) begin
      slot_mem[cnt_r[IW-1:0]] <= src;
    end
    if (rd_go) begin
      rd_data_r <= slot_mem[rd_idx_r[IW-1:0]];
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.res;
      out_filled_r <= mpls_pkg::CNT_O_W'(cnt_r);
      out_next_r   <= full ? mpls_pkg::CNT_O_W'(LAST_C) : mpls_pkg::CNT_O_W'(cnt_r);
      out_learn_r  <= learn_r;
      out_wait_r   <= wait_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_filled_count = out_filled_r;
  assign out_next_slot    = out_next_r;
  assign out_learning_on  = out_learn_r;
  assign out_release_wait = out_wait_r;

endmodule

// ===== rtl/core/mpls_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIDI pad learn sequencer controller
// Sequences one word: decode, table scan, update and result handoff.
// ----------------------------------------------------------------------------
module mpls_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mpls_pkg::stat_t stat,
  output mpls_pkg::cmd_t  cmd
);

  mpls_pkg::state_t  state_r;
  mpls_pkg::state_t  state_nxt;
  mpls_pkg::status_t res_r;
  mpls_pkg::status_t res_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              out_free;

  assign out_free = !out_vld_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpls_pkg::S_IDLE: begin
        if (in_valid) state_nxt = mpls_pkg::S_EVAL;
      end
      mpls_pkg::S_EVAL: begin
        if (stat.is_start || stat.waiting || stat.ignore || stat.early || stat.cnt_zero)
          state_nxt = mpls_pkg::S_DONE;
        else
          state_nxt = mpls_pkg::S_SCAN;
      end
      mpls_pkg::S_SCAN: begin
        if (stat.scan_hit || stat.scan_end) state_nxt = mpls_pkg::S_DONE;
      end
      mpls_pkg::S_DONE: begin
        if (out_free) state_nxt = mpls_pkg::S_IDLE;
      end
      default: state_nxt = mpls_pkg::S_IDLE;
    endcase
  end

  // commands and result code
  always_comb begin
    cmd         = '0;
    cmd.res     = res_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    out_vld_nxt = out_vld_r && !out_ready;
    unique case (state_r)
      mpls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mpls_pkg::S_EVAL: begin
        if (stat.is_start) begin
          cmd.start = 1'b1;
          res_nxt   = mpls_pkg::ST_STARTED;
        end else if (stat.waiting) begin
          cmd.rel_chk = 1'b1;
          res_nxt     = mpls_pkg::ST_GUARDED;
        end else if (stat.ignore) begin
          res_nxt = mpls_pkg::ST_IGNORED;
        end else if (stat.early) begin
          res_nxt = mpls_pkg::ST_GUARDED;
        end else if (stat.cnt_zero) begin
          cmd.capture = 1'b1;
          res_nxt     = stat.cap_last ? mpls_pkg::ST_COMPLETE : mpls_pkg::ST_CAPTURED;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      mpls_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          res_nxt = mpls_pkg::ST_DUPLICATE;
        end else if (stat.scan_end) begin
          cmd.capture = 1'b1;
          res_nxt     = stat.cap_last ? mpls_pkg::ST_COMPLETE : mpls_pkg::ST_CAPTURED;
        end
      end
      mpls_pkg::S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mpls_pkg::S_IDLE;
      res_r     <= mpls_pkg::ST_IGNORED;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_r     <= res_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;

endmodule

// ===== rtl/core/midi_pad_learn_sequencer_unit.sv =====
// Each word goes from idle (accept) through the evaluate state, the scan state when it
// needs a scan of the learned slots (one slot table read per cycle), and the done state,
// which loads the result register once that register is free; a new word is taken
// while the previous result waits in the output register.
// Reset (rst_n low, synchronous): learning off, count, deadline and release
// wait cleared, guard time back to 350000 us; slot table contents are kept.
// ----------------------------------------------------------------------------
// MIDI pad learn sequencer, top level
// Learns pad sources into a slot table with release wait and guard deadline.
// ----------------------------------------------------------------------------
module midi_pad_learn_sequencer_unit #(
  parameter int TABLE_SLOTS = mpls_pkg::TABLE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mpls_in_if.sink    in_if,
  mpls_out_if.source out_if,
  mpls_cfg_if.sink   cfg_if
);

  mpls_pkg::cmd_t  cmd;
  mpls_pkg::stat_t stat;

  // guard time register always takes writes
  assign cfg_if.ready = 1'b1;

  mpls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpls_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_if.kind),
    .in_msg_type      (in_if.msg_type),
    .in_channel       (in_if.channel),
    .in_data_one      (in_if.data_one),
    .in_data_two      (in_if.data_two),
    .in_cable         (in_if.cable),
    .in_time_us       (in_if.time_us),
    .cfg_valid        (cfg_if.valid),
    .cfg_data         (cfg_if.data),
    .out_status       (out_if.status),
    .out_filled_count (out_if.filled_count),
    .out_next_slot    (out_if.next_slot),
    .out_learning_on  (out_if.learning_on),
    .out_release_wait (out_if.release_wait)
  );

endmodule

// ===== rtl/core/mpls_chk.sv =====
// ----------------------------------------------------------------------------
// MIDI pad learn sequencer port checker
// Result channel checks, bound to the top level.
// ----------------------------------------------------------------------------
module mpls_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [3:0] out_filled_count,
  input logic       out_learning_on,
  input logic       out_release_wait
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_filled_count) && $stable(out_learning_on) && $stable(out_release_wait))
    else $error("result word changed while stalled");

  // start leaves an empty table, learning on, no release wait
  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mpls_pkg::ST_STARTED) |->
    (out_filled_count == 4'd0) && out_learning_on && !out_release_wait)
    else $error("started result with wrong state");

  // capture keeps learning and waits for release
  a_captured: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mpls_pkg::ST_CAPTURED) |->
    out_learning_on && out_release_wait && (out_filled_count != 4'd0))
    else $error("captured result with wrong state");

  // complete ends learning
  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mpls_pkg::ST_COMPLETE) |-> !out_learning_on)
    else $error("complete result with learning still on");

endmodule

bind midi_pad_learn_sequencer_unit mpls_chk u_mpls_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_status       (out_if.status),
  .out_filled_count (out_if.filled_count),
  .out_learning_on  (out_if.learning_on),
  .out_release_wait (out_if.release_wait)
);
